// ----- design/itwt_pkg.sv -----
`default_nettype none

package itwt_pkg;

    // Widths of the request and result fields.
    localparam int VALUE_W = 31;
    localparam int CODE_W  = 5;
    localparam int DIGITS  = 10;
    localparam int BCD_W   = 4 * DIGITS;

    // Conversion takes one input bit per cycle; the counter stops at the last one.
    localparam logic [4:0] CONV_LAST = 5'(VALUE_W - 1);

    // Word codes.
    localparam logic [CODE_W-1:0] W_ZERO     = 5'd0;
    localparam logic [CODE_W-1:0] W_TEN      = 5'd10;
    localparam logic [CODE_W-1:0] W_TENS_OFS = 5'd18;
    localparam logic [CODE_W-1:0] W_HUNDRED  = 5'd28;
    localparam logic [CODE_W-1:0] W_THOUSAND = 5'd29;
    localparam logic [CODE_W-1:0] W_MILLION  = 5'd30;
    localparam logic [CODE_W-1:0] W_BILLION  = 5'd31;

    // Three-digit groups, most significant first.
    localparam logic [1:0] GRP_BILLION  = 2'd0;
    localparam logic [1:0] GRP_MILLION  = 2'd1;
    localparam logic [1:0] GRP_THOUSAND = 2'd2;
    localparam logic [1:0] GRP_UNITS    = 2'd3;

    // Word slots inside one group, in reading order.
    localparam logic [2:0] SLOT_HUND_DIGIT = 3'd0;
    localparam logic [2:0] SLOT_HUNDRED    = 3'd1;
    localparam logic [2:0] SLOT_TENS       = 3'd2;
    localparam logic [2:0] SLOT_UNIT       = 3'd3;
    localparam logic [2:0] SLOT_SCALE      = 3'd4;
    localparam int         SLOTS           = 5;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       shift;
        logic       step;
        logic       emit_zero;
        logic [1:0] grp;
        logic [2:0] slot;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emits;
        logic last;
        logic zero;
        logic out_full;
    } status_t;

    typedef struct packed {
        logic              emit;
        logic [CODE_W-1:0] code;
    } word_t;

    // Word produced by one slot of a group with digits h, t, u.
    function automatic word_t slot_word(input logic [3:0] h, input logic [3:0] t,
                                        input logic [3:0] u, input logic [1:0] grp,
                                        input logic [2:0] slot);
        word_t w;
        logic  nz;
        w.emit = 1'b0;
        w.code = W_ZERO;
        nz     = (h != 4'd0) || (t != 4'd0) || (u != 4'd0);
        case (slot)
            SLOT_HUND_DIGIT:
            begin
                w.emit = (h != 4'd0);
                w.code = {1'b0, h};
            end
            SLOT_HUNDRED:
            begin
                w.emit = (h != 4'd0);
                w.code = W_HUNDRED;
            end
            SLOT_TENS:
            begin
                w.emit = (t != 4'd0) || (u != 4'd0);
                if (t >= 4'd2)
                    w.code = W_TENS_OFS + {1'b0, t};
                else if (t == 4'd1)
                    w.code = W_TEN + {1'b0, u};
                else
                    w.code = {1'b0, u};
            end
            SLOT_UNIT:
            begin
                w.emit = (t >= 4'd2) && (u != 4'd0);
                w.code = {1'b0, u};
            end
            SLOT_SCALE:
            begin
                w.emit = nz && (grp != GRP_UNITS);
                case (grp)
                    GRP_BILLION:  w.code = W_BILLION;
                    GRP_MILLION:  w.code = W_MILLION;
                    GRP_THOUSAND: w.code = W_THOUSAND;
                    default:      w.code = W_ZERO;
                endcase
            end
            default:
            begin
                w.emit = 1'b0;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- design/itwt_in_if.sv -----
`default_nettype none

// Request channel: one integer per request.
interface itwt_in_if;
    logic        valid;
    logic        ready;
    logic [30:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- design/itwt_out_if.sv -----
`default_nettype none

// Result channel: one word code per request on this side.
interface itwt_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] word_code;
    logic       last_word;

    modport source (output valid, output word_code, output last_word, input ready);
    modport sink (input valid, input word_code, input last_word, output ready);
endinterface

`default_nettype wire

// ----- design/itwt_ctrl.sv -----
`default_nettype none

module itwt_ctrl
    import itwt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] grp_reg, grp_next;
    logic [2:0] slot_reg, slot_next;

    // State and sequencing registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 5'd0;
            grp_reg   <= GRP_BILLION;
            slot_reg  <= SLOT_HUND_DIGIT;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            grp_reg   <= grp_next;
            slot_reg  <= slot_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        grp_next      = grp_reg;
        slot_next     = slot_reg;
        cmd.load      = 1'b0;
        cmd.shift     = 1'b0;
        cmd.step      = 1'b0;
        cmd.emit_zero = 1'b0;
        cmd.grp       = grp_reg;
        cmd.slot      = slot_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = 5'd0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == CONV_LAST)
                begin
                    grp_next   = GRP_BILLION;
                    slot_next  = SLOT_HUND_DIGIT;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.zero)
                begin
                    // A zero value reads as the single word Zero.
                    if (!status.out_full)
                    begin
                        cmd.emit_zero = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else if (!(status.emits && status.out_full))
                begin
                    // One slot per cycle; a slot that emits waits for a free output.
                    cmd.step = 1'b1;
                    if ((status.emits && status.last) ||
                        (grp_reg == GRP_UNITS && slot_reg == SLOT_SCALE))
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (slot_reg == SLOT_SCALE)
                    begin
                        slot_next = SLOT_HUND_DIGIT;
                        grp_next  = grp_reg + 2'd1;
                    end
                    else
                    begin
                        slot_next = slot_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/itwt_dp.sv -----
`default_nettype none

module itwt_dp
    import itwt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output status_t                 status,
    input  wire logic [VALUE_W-1:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [CODE_W-1:0]       word_code,
    output logic                    last_word
);

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic               last_reg, last_next;
    logic               valid_reg, valid_next;
    logic [3:0]         dig_h, dig_t, dig_u;
    logic               lower_nz;
    logic               more_in_grp;
    logic               load_out;
    word_t              cur;
    word_t              probe;

    // Shift-add-3 step: digits of five or more get three added before the shift.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (cmd.load)
        begin
            bin_next = value;
            bcd_next = '0;
        end
        else if (cmd.shift)
        begin
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // Digits of the current group and whether any lower group is nonzero.
    always_comb
    begin
        case (cmd.grp)
            GRP_BILLION:
            begin
                dig_h    = 4'd0;
                dig_t    = 4'd0;
                dig_u    = bcd_reg[39:36];
                lower_nz = (bcd_reg[35:0] != '0);
            end
            GRP_MILLION:
            begin
                dig_h    = bcd_reg[35:32];
                dig_t    = bcd_reg[31:28];
                dig_u    = bcd_reg[27:24];
                lower_nz = (bcd_reg[23:0] != '0);
            end
            GRP_THOUSAND:
            begin
                dig_h    = bcd_reg[23:20];
                dig_t    = bcd_reg[19:16];
                dig_u    = bcd_reg[15:12];
                lower_nz = (bcd_reg[11:0] != '0);
            end
            default:
            begin
                dig_h    = bcd_reg[11:8];
                dig_t    = bcd_reg[7:4];
                dig_u    = bcd_reg[3:0];
                lower_nz = 1'b0;
            end
        endcase
    end

    // Word of the current slot, and whether a later slot of this group speaks.
    always_comb
    begin
        cur         = slot_word(dig_h, dig_t, dig_u, cmd.grp, cmd.slot);
        more_in_grp = 1'b0;
        probe       = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            probe = slot_word(dig_h, dig_t, dig_u, cmd.grp, 3'(s));
            if (3'(s) > cmd.slot && probe.emit)
                more_in_grp = 1'b1;
        end
    end

    assign status.emits    = cur.emit;
    assign status.last     = !(more_in_grp || lower_nz);
    assign status.zero     = (bcd_reg == '0);
    assign status.out_full = valid_reg && !out_ready;

    // Output register.
    assign load_out = cmd.emit_zero || (cmd.step && cur.emit);

    always_comb
    begin
        code_next  = code_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !out_ready;
        if (cmd.emit_zero)
        begin
            code_next = W_ZERO;
            last_next = 1'b1;
        end
        else if (load_out)
        begin
            code_next = cur.code;
            last_next = status.last;
        end
        if (load_out)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign word_code = code_reg;
    assign last_word = last_reg;

endmodule

`default_nettype wire

// ----- design/integer_to_word_tokens_top.sv -----
`default_nettype none

// Reads a 31-bit non-negative integer out as English word codes, one word per
// result request, most significant group first, with last_word set on the final
// word. A value is taken in, then converted to ten decimal digits by a shift-add-3
// loop, then a word sequencer visits the five word slots of each of the four
// three-digit groups at one slot per cycle and stops after the final word; a slot
// with a word waits while the output register is full. The units group never
// speaks a scale word. The next value is accepted while the final word still
// waits in the output register.
module integer_to_word_tokens_top
    import itwt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    itwt_in_if.sink    in_ch,
    itwt_out_if.source out_ch
);

    cmd_t    cmd;
    status_t status;

    itwt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    itwt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (in_ch.value),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .word_code (out_ch.word_code),
        .last_word (out_ch.last_word)
    );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itwt_pkg::*;

    // One word of a reading as it should appear on the result channel.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } word_due_t;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES = 60;
    localparam int unsigned MAX_VALUE   = 32'h7FFF_FFFF;

    localparam int unsigned DIRECTED_N = 24;
    localparam int unsigned DIRECTED_VALUES [DIRECTED_N] = '{
        0, 1, 9, 10, 11, 15, 19, 20, 21, 45, 99, 100, 101, 110, 119, 999,
        1000, 100010, 7000013, 1000000, 1000000000, 1001001001, 2000000000,
        2147483647
    };

    logic clk = 1'b0;
    logic rst_n;

    itwt_in_if  in_ch ();
    itwt_out_if out_ch ();

    integer_to_word_tokens_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    word_due_t         words_due [$];
    logic [CODE_W-1:0] reading_codes [$];
    int unsigned       mismatch_count = 0;
    int unsigned       burst_left = 0;
    int unsigned       quiet_cycles = 0;

    // Free-running clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Append the words of one three-digit group, then its scale word if it has one.
    function automatic void read_group(input int unsigned grp, input logic [CODE_W-1:0] scale);
        int unsigned hund;
        int unsigned rest;
        hund = grp / 100;
        rest = grp % 100;
        if (grp == 0)
            return;
        if (hund != 0)
        begin
            reading_codes.push_back(CODE_W'(hund));
            reading_codes.push_back(W_HUNDRED);
        end
        if (rest != 0)
        begin
            if (rest < 20)
                reading_codes.push_back(CODE_W'(rest));
            else
            begin
                reading_codes.push_back(W_TENS_OFS + CODE_W'(rest / 10));
                if (rest % 10 != 0)
                    reading_codes.push_back(CODE_W'(rest % 10));
            end
        end
        if (scale != W_ZERO)
            reading_codes.push_back(scale);
    endfunction

    // Work out the full word sequence for one accepted value.
    function automatic void predict_reading(input logic [VALUE_W-1:0] value);
        int unsigned v;
        word_due_t   w;
        v = int'(value);
        reading_codes.delete();
        if (v == 0)
            reading_codes.push_back(W_ZERO);
        else
        begin
            read_group(v / 1000000000, W_BILLION);
            read_group((v / 1000000) % 1000, W_MILLION);
            read_group((v / 1000) % 1000, W_THOUSAND);
            read_group(v % 1000, W_ZERO);
        end
        foreach (reading_codes[i])
        begin
            w.code = reading_codes[i];
            w.last = (i == reading_codes.size() - 1);
            words_due.push_back(w);
        end
    endfunction

    // Send one request; the sender runs in bursts separated by idle gaps.
    task automatic send_value(input int unsigned value);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 10);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 12);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= value[VALUE_W-1:0];
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_reading(value[VALUE_W-1:0]);
        burst_left--;
    endtask

    // Hold the request side idle until every outstanding word has come back.
    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (words_due.size() != 0)
            @(posedge clk);
    endtask

    // Random value built from groups, each one zero a third of the time.
    function automatic int unsigned grouped_value();
        longint unsigned v;
        int unsigned     grp [3];
        foreach (grp[i])
            grp[i] = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 999);
        v = longint'($urandom_range(0, 2)) * 1000000000 + grp[0] * 1000000 +
            grp[1] * 1000 + grp[2];
        if (v > MAX_VALUE)
            v = v - 1000000000;
        return int'(v);
    endfunction

    task automatic test_directed_values();
        for (int i = 0; i < DIRECTED_N; i++)
            send_value(DIRECTED_VALUES[i]);
    endtask

    task automatic test_zero_groups();
        for (int i = 0; i < 100; i++)
            send_value(grouped_value());
    endtask

    // Full-range values, with one pause for the results to drain midway.
    task automatic test_uniform_values();
        for (int i = 0; i < 150; i++)
        begin
            if (i == 75)
                hold_until_drained();
            send_value($urandom() & MAX_VALUE);
        end
    endtask

    // Values below one thousand, then every single-bit value.
    task automatic test_small_values();
        for (int i = 0; i < 70; i++)
            send_value($urandom_range(0, 999));
        for (int i = 0; i < VALUE_W; i++)
            send_value(32'd1 << i);
    endtask

    // Receiver stalls: the mode changes now and then between always ready,
    // mostly ready, mostly stalled and a fixed periodic pattern.
    int unsigned ready_phase_left = 0;
    int unsigned ready_mode = 0;
    int unsigned ready_tick = 0;
    always @(posedge clk)
    begin
        if (ready_phase_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_phase_left = $urandom_range(20, 200);
        end
        ready_phase_left--;
        ready_tick++;
        case (ready_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2: out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= ((ready_tick % 7) < 4);
        endcase
    end

    // Compare each accepted word with the oldest outstanding one.
    always @(posedge clk)
    begin
        word_due_t due;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (words_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: code %0d last %0b",
                             out_ch.word_code, out_ch.last_word);
            end
            else
            begin
                due = words_due.pop_front();
                if (out_ch.word_code !== due.code || out_ch.last_word !== due.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("word mismatch: expected code %0d last %0b, got code %0d last %0b",
                                 due.code, due.last, out_ch.word_code, out_ch.last_word);
                end
            end
        end
    end

    // Watchdog: too long without any request or word moving ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Reset, then the tests in turn with a drain between each.
    initial
    begin
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_values();
        hold_until_drained();
        test_zero_groups();
        hold_until_drained();
        test_uniform_values();
        hold_until_drained();
        test_small_values();
        hold_until_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && words_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
design/itwt_pkg.sv
design/itwt_in_if.sv
design/itwt_out_if.sv
design/itwt_ctrl.sv
design/itwt_dp.sv
design/integer_to_word_tokens_top.sv
dv/tb.sv
